>>> hdl/assert_macros.svh
// -----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the battery level smoother RTL.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be true at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

>>> hdl/bls_pkg.sv
// -----------------------------------------------------------------------------
// bls_pkg
// Types and constants shared by the battery level smoother modules.
// -----------------------------------------------------------------------------
package bls_pkg;

    localparam int RAW_W   = 8;
    localparam int LVL_W   = 7;
    localparam int TICK_W  = 12;
    localparam int RUN_W   = 3;
    localparam int CFG_IDX_W = 2;

    typedef logic [RAW_W-1:0]     t_raw;
    typedef logic [LVL_W-1:0]     t_level;
    typedef logic [TICK_W-1:0]    t_tick;
    typedef logic [RUN_W-1:0]     t_run;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // register indexes of the configuration port
    localparam t_cfg_idx CFG_UP_STEP     = 2'd0;
    localparam t_cfg_idx CFG_DOWN_STEP   = 2'd1;
    localparam t_cfg_idx CFG_ZERO_RESTART = 2'd2;

    localparam t_tick UP_STEP_RESET      = 12'd420;
    localparam t_tick DOWN_STEP_RESET    = 12'd60;
    localparam t_tick ZERO_RESTART_RESET = 12'd1800;

    localparam t_raw   LVL_MAX        = 8'd100;
    localparam t_raw   LVL_TOP_LESS1  = 8'd99;
    localparam t_raw   LVL_NEAR_FULL  = 8'd95;
    localparam t_raw   LVL_DESC_FLOOR = 8'd90;
    localparam t_raw   LVL_ZERO_SNAP  = 8'd2;
    localparam t_level SHOWN_RESET    = 7'd2;
    localparam t_run   INV_RUN_LIMIT  = 3'd5;

    typedef struct packed {
        t_tick up_step;
        t_tick down_step;
        t_tick zero_restart;
    } t_cfg;

    typedef struct packed {
        t_level shown_level;
        logic   restart_request;
        logic   raw_invalid;
    } t_result;

endpackage

>>> hdl/bls_in_if.sv
// -----------------------------------------------------------------------------
// bls_in_if
// Input channel: raw gauge reading and charger bit, valid/ready.
// -----------------------------------------------------------------------------
interface bls_in_if import bls_pkg::*;;
    logic valid;
    logic ready;
    t_raw raw_level;
    logic charger_present;

    modport source (output valid, output raw_level, output charger_present, input ready);
    modport sink   (input valid, input raw_level, input charger_present, output ready);
endinterface

>>> hdl/bls_out_if.sv
// -----------------------------------------------------------------------------
// bls_out_if
// Result channel: smoothed level and status flags, valid/ready.
// -----------------------------------------------------------------------------
interface bls_out_if import bls_pkg::*;;
    logic   valid;
    logic   ready;
    t_level shown_level;
    logic   restart_request;
    logic   raw_invalid;

    modport source (output valid, output shown_level, output restart_request,
                    output raw_invalid, input ready);
    modport sink   (input valid, input shown_level, input restart_request,
                    input raw_invalid, output ready);
endinterface

>>> hdl/bls_cfg.sv
// -----------------------------------------------------------------------------
// bls_cfg
// Configuration register file: tick thresholds written through a plain port.
// -----------------------------------------------------------------------------
module bls_cfg import bls_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_we,
    input  t_cfg_idx i_cfg_idx,
    input  t_tick    i_cfg_data,
    output t_cfg     o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_UP_STEP:      n_cfg.up_step      = i_cfg_data;
                CFG_DOWN_STEP:    n_cfg.down_step    = i_cfg_data;
                CFG_ZERO_RESTART: n_cfg.zero_restart = i_cfg_data;
                default:          n_cfg = r_cfg;   // unused index, write dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.up_step      <= UP_STEP_RESET;
            r_cfg.down_step    <= DOWN_STEP_RESET;
            r_cfg.zero_restart <= ZERO_RESTART_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hdl/bls_step.sv
// -----------------------------------------------------------------------------
// bls_step
// Smoothing state and per-tick update logic. State advances on i_en.
// -----------------------------------------------------------------------------
module bls_step import bls_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_raw    i_raw,
    input  logic    i_chg,
    input  t_cfg    i_cfg,
    output t_result o_res
);

    t_level r_shown,    n_shown;
    t_run   r_inv_run,  n_inv_run;
    t_tick  r_nf_cnt,   n_nf_cnt;
    logic   r_jumped,   n_jumped;
    t_tick  r_zero_run, n_zero_run;
    logic   r_qs_done,  n_qs_done;

    always_comb begin
        t_raw  cap;
        t_raw  c;
        t_raw  cap_p1;
        t_raw  cap_m1;
        t_tick nf_inc;
        t_tick zr_inc;
        t_run  run_inc;
        logic  invalid;
        logic  restart;
        logic  against;
        logic  snap;

        cap     = {1'b0, r_shown};
        cap_p1  = cap + 8'd1;
        cap_m1  = cap - 8'd1;
        c       = i_raw;
        invalid = (i_raw > LVL_MAX);
        restart = 1'b0;
        nf_inc  = (r_nf_cnt == '1) ? r_nf_cnt : r_nf_cnt + 12'd1;
        zr_inc  = (r_zero_run == '1) ? r_zero_run : r_zero_run + 12'd1;
        run_inc = (r_inv_run == '1) ? r_inv_run : r_inv_run + 3'd1;

        n_inv_run  = r_inv_run;
        n_nf_cnt   = r_nf_cnt;
        n_jumped   = r_jumped;
        n_zero_run = r_zero_run;
        n_qs_done  = r_qs_done;

        // run of invalid readings
        if (invalid) begin
            n_inv_run = run_inc;
            if (run_inc > INV_RUN_LIMIT) begin
                restart   = 1'b1;
                n_inv_run = '0;
            end
        end else begin
            n_inv_run = '0;
        end

        // hold back a one-step move against the charge direction
        against = (i_chg && (cap != '0) && (c == cap_m1)) || (!i_chg && (c == cap_p1));
        snap    = ((c == '0) && (cap <= LVL_ZERO_SNAP))
                || ((c == LVL_MAX) && (cap == LVL_TOP_LESS1));
        if (against && !snap) begin
            c = cap;
        end

        // creep up near full while charging, forced descent after a jump
        if (i_chg && (c >= LVL_NEAR_FULL) && (c <= cap)) begin
            n_nf_cnt = nf_inc;
            if (nf_inc >= i_cfg.up_step) begin
                c        = (cap_p1 > LVL_MAX) ? LVL_MAX : cap_p1;
                n_jumped = 1'b1;
                n_nf_cnt = '0;
            end else begin
                c = cap;
            end
        end else if (!i_chg && (c <= cap) && (c >= LVL_DESC_FLOOR) && r_jumped) begin
            n_nf_cnt = nf_inc;
            if (nf_inc >= i_cfg.down_step) begin
                n_nf_cnt = '0;
                // cap of zero means allow is negative: raw always caught up
                if ((cap == '0) || (c >= cap_m1)) begin
                    n_jumped = 1'b0;
                end else begin
                    c = cap_m1;
                end
            end else begin
                c = cap;
            end
        end else begin
            n_nf_cnt = '0;
        end

        // zero reading while charging
        if (i_chg && (c == '0)) begin
            n_zero_run = zr_inc;
            if ((zr_inc >= i_cfg.zero_restart) && !r_qs_done) begin
                restart    = 1'b1;
                n_qs_done  = 1'b1;
                n_zero_run = '0;
            end
        end else if (r_qs_done && !i_chg) begin
            n_qs_done = 1'b0;
        end

        n_shown = (c <= LVL_MAX) ? c[LVL_W-1:0] : r_shown;

        o_res.shown_level     = n_shown;
        o_res.restart_request = restart;
        o_res.raw_invalid     = invalid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shown    <= SHOWN_RESET;
            r_inv_run  <= '0;
            r_nf_cnt   <= '0;
            r_jumped   <= 1'b0;
            r_zero_run <= '0;
            r_qs_done  <= 1'b0;
        end else if (i_en) begin
            r_shown    <= n_shown;
            r_inv_run  <= n_inv_run;
            r_nf_cnt   <= n_nf_cnt;
            r_jumped   <= n_jumped;
            r_zero_run <= n_zero_run;
            r_qs_done  <= n_qs_done;
        end
    end

endmodule

>>> hdl/battery_level_smoother.sv
// -----------------------------------------------------------------------------
// battery_level_smoother
// Smooths the gauge's state-of-charge readings into a displayed percentage
// and raises gauge-restart requests.
//
//   port      dir  payload                                        transfer
//   i_item    in   raw_level[7:0], charger_present                valid & ready
//   o_result  out  shown_level[6:0], restart_request, raw_invalid valid & ready
//   i_cfg_*   in   idx[1:0], data[11:0]                           we
//
// One reading per cycle sustained while o_result.ready holds; each reading
// passes through the input register, then the result register.
// State updates when a reading moves from the input register to the result
// register, so the next reading always sees the previous one's effect.
// Synchronous active-low reset; a stalled result register backs up into the
// input register, and i_item.ready drops only when both are full.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module battery_level_smoother import bls_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bls_in_if.sink    i_item,
    bls_out_if.source o_result,
    input  logic      i_cfg_we,
    input  t_cfg_idx  i_cfg_idx,
    input  t_tick     i_cfg_data
);

    logic    r_in_valid;
    t_raw    r_in_raw;
    logic    r_in_chg;
    logic    r_out_valid;
    t_result r_out;
    t_result step_res;
    t_cfg    cfg;
    logic    adv;

    assign adv          = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || adv;

    bls_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    bls_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_raw   (r_in_raw),
        .i_chg   (r_in_chg),
        .i_cfg   (cfg),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_raw <= i_item.raw_level;
            r_in_chg <= i_item.charger_present;
        end
        if (adv) begin
            r_out <= step_res;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.shown_level     = r_out.shown_level;
    assign o_result.restart_request = r_out.restart_request;
    assign o_result.raw_invalid     = r_out.raw_invalid;

    `ASSERT_NEVER(a_level_range, i_clk, i_rst_n, r_out_valid && (r_out.shown_level > LVL_MAX[LVL_W-1:0]), "shown level above full scale")
    `ASSERT_CLK(a_in_hold, i_clk, i_rst_n, (r_in_valid && !adv) |=> (r_in_valid && $stable(r_in_raw) && $stable(r_in_chg)), "pending reading lost or overwritten")
    `ASSERT_CLK(a_adv_result, i_clk, i_rst_n, adv |=> r_out_valid, "advanced reading produced no result")

endmodule
